>>> src/adaptive_playout_buffer_defines.svh
// Assertion macros for the adaptive playout buffer.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef ADAPTIVE_PLAYOUT_BUFFER_DEFINES_SVH
`define ADAPTIVE_PLAYOUT_BUFFER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define APLB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define APLB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/aplb_pkg.sv
// Shared types, sizes and codes of the adaptive playout buffer.
// No dependencies; every module file imports it.
`timescale 1ns / 1ps
`default_nettype none

package aplb_pkg;

   localparam int STORE_BYTES = 65536;
   localparam int TAG_DEPTH   = 1024;
   localparam int READ_MAX    = 64;

   localparam int PTR_W   = $clog2(STORE_BYTES);
   localparam int FILL_W  = $clog2(STORE_BYTES + 1);
   localparam int TPTR_W  = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
   localparam int TFILL_W = $clog2(TAG_DEPTH + 1);

   localparam int LEN_W   = 7;
   localparam int START_W = 17;
   localparam int FRAME_W = 7;
   localparam int LEVEL_W = 17;
   localparam int TAG_W   = 32;
   localparam int CMP_W   = (FILL_W > START_W) ? FILL_W : START_W;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic REG_START_LEVEL = 1'b0;
   localparam logic REG_FRAME_BYTES = 1'b1;

   localparam logic [START_W-1:0] START_LEVEL_RESET = START_W'(9600);
   localparam logic [FRAME_W-1:0] FRAME_BYTES_RESET = FRAME_W'(64);

   localparam logic signed [TAG_W-1:0] NO_TAG = -32'sd1;

   typedef struct packed {
      logic [1:0]              kind;
      logic [7:0]              wr_byte;
      logic                    chunk_end;
      logic                    tag_present;
      logic signed [TAG_W-1:0] tag_in;
      logic [LEN_W-1:0]        req_len;
      logic                    req_tagged;
   } req_word_type;

   typedef struct packed {
      logic [7:0]              rd_byte;
      logic                    is_silence;
      logic                    run_last;
      logic signed [TAG_W-1:0] tag_out;
      logic                    buffering_now;
      logic [LEVEL_W-1:0]      level;
   } rsp_word_type;

   typedef struct packed {
      logic [START_W-1:0] start_level;
      logic [FRAME_W-1:0] frame_bytes;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic issue;
      logic issue_data;
      logic issue_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic             run_go;
      logic [LEN_W-1:0] run_len;
      logic [LEN_W-1:0] run_ndata;
      logic             issue_ok;
   } dp_status_type;

endpackage

`default_nettype wire

>>> src/aplb_csr.sv
// Configuration registers of the playout buffer behind an APB-style port.
// Depends on aplb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aplb_csr
   import aplb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_START_LEVEL: cfg_in.start_level = csr_pwdata[START_W-1:0];
            REG_FRAME_BYTES: cfg_in.frame_bytes = csr_pwdata[FRAME_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_level <= START_LEVEL_RESET;
         cfg_ff.frame_bytes <= FRAME_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_START_LEVEL: csr_prdata = 32'(cfg_ff.start_level);
         REG_FRAME_BYTES: csr_prdata = 32'(cfg_ff.frame_bytes);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> src/aplb_ctrl.sv
// Sequencer of the playout buffer: takes words and steps a read run byte by byte.
// Depends on aplb_pkg; drives the datapath through ctrl_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module aplb_ctrl
   import aplb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] ndata_ff, ndata_in;
   logic [LEN_W-1:0] idx_next;

   assign idx_next  = idx_ff + LEN_W'(1);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      ndata_in = ndata_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.run_go) begin
               state_in = ST_RUN;
               len_in   = status.run_len;
               ndata_in = status.run_ndata;
               idx_in   = '0;
            end
         end
         ST_RUN: begin
            // one byte per cycle whenever the read stage has room
            if (status.issue_ok) begin
               cmd.issue      = 1'b1;
               cmd.issue_data = (idx_ff < ndata_ff);
               cmd.issue_last = (idx_next == len_ff);
               idx_in         = idx_next;
               if (idx_next == len_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      ndata_ff <= ndata_in;
   end

endmodule

`default_nettype wire

>>> src/aplb_dp.sv
// Datapath of the playout buffer: byte ring, tag ring, read plan and result stages.
// Depends on aplb_pkg; commanded by aplb_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module aplb_dp
   import aplb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  req_word_type  req_data,
   input  cfg_type       cfg,
   input  ctrl_cmd_type  cmd,
   input  wire logic     rsp_stall,
   output logic          rsp_valid,
   output rsp_word_type  rsp_data,
   output dp_status_type status
);

   // ring state
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               buffering_ff, buffering_in;
   logic [TPTR_W-1:0]  tag_wr_ptr_ff, tag_wr_ptr_in;
   logic [TPTR_W-1:0]  tag_rd_ptr_ff, tag_rd_ptr_in;
   logic [TFILL_W-1:0] tag_fill_ff, tag_fill_in;
   logic [FRAME_W-1:0] chunk_pos_ff, chunk_pos_in;

   // per-run state
   logic               run_tag_ok_ff, run_tag_ok_in;
   logic               run_pop_ff, run_pop_in;
   logic               run_buf_ff, run_buf_in;
   logic [LEVEL_W-1:0] run_level_ff, run_level_in;
   logic [FRAME_W-1:0] frm_cnt_ff, frm_cnt_in;

   // result stages
   logic         s1_valid_ff, s1_valid_in;
   rsp_word_type s1_word_ff, s1_word_in;
   logic         s1_data_ff, s1_data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         s1_move;

   // memories
   logic [7:0]              byte_mem [STORE_BYTES];
   logic signed [TAG_W-1:0] tag_mem  [TAG_DEPTH];
   logic [7:0]              byte_dout_ff;
   logic signed [TAG_W-1:0] tag_dout_ff;

   logic               do_write, do_read, do_clear;
   logic [LEN_W-1:0]   len_sat;
   logic [FRAME_W-1:0] eff_frame, pos_inc, frm_inc;
   logic [CMP_W-1:0]   fill_x, start_x, len_x;
   logic               fill_zero, buf0, silent, full;
   logic               tag_push, byte_rd_en;
   logic [PTR_W-1:0]   wr_ptr_next, rd_ptr_next;
   logic [TPTR_W-1:0]  tag_wr_next, tag_rd_next;

   assign do_write = cmd.accept && (req_data.kind == KIND_WRITE);
   assign do_read  = cmd.accept && (req_data.kind == KIND_READ);
   assign do_clear = cmd.accept && (req_data.kind == KIND_CLEAR);

   assign len_sat   = (req_data.req_len > LEN_W'(READ_MAX)) ? LEN_W'(READ_MAX) : req_data.req_len;
   assign eff_frame = (cfg.frame_bytes == '0) ? FRAME_W'(1) : cfg.frame_bytes;
   assign pos_inc   = chunk_pos_ff + FRAME_W'(1);
   assign frm_inc   = frm_cnt_ff + FRAME_W'(1);

   assign fill_x    = CMP_W'(fill_ff);
   assign start_x   = CMP_W'(cfg.start_level);
   assign len_x     = CMP_W'(len_sat);
   assign fill_zero = (fill_ff == '0);
   assign buf0      = buffering_ff || fill_zero;
   assign silent    = buf0 && (fill_x < start_x);
   assign full      = (fill_x >= len_x);

   assign wr_ptr_next = (wr_ptr_ff == PTR_W'(STORE_BYTES - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_next = (rd_ptr_ff == PTR_W'(STORE_BYTES - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign tag_wr_next = (tag_wr_ptr_ff == TPTR_W'(TAG_DEPTH - 1)) ? '0
                        : tag_wr_ptr_ff + TPTR_W'(1);
   assign tag_rd_next = (tag_rd_ptr_ff == TPTR_W'(TAG_DEPTH - 1)) ? '0
                        : tag_rd_ptr_ff + TPTR_W'(1);

   assign tag_push   = do_write && (pos_inc >= eff_frame) && req_data.tag_present;
   assign byte_rd_en = cmd.issue && cmd.issue_data;

   assign s1_move = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   // read plan, seen by the sequencer before it takes the word
   always_comb begin
      status.run_go   = (req_data.kind == KIND_READ) && (len_sat != '0);
      status.run_len  = len_sat;
      if (silent) begin
         status.run_ndata = '0;
      end else if (full) begin
         status.run_ndata = len_sat;
      end else begin
         status.run_ndata = fill_ff[LEN_W-1:0];
      end
      status.issue_ok = !s1_valid_ff || s1_move;
   end

   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      fill_in       = fill_ff;
      buffering_in  = buffering_ff;
      tag_wr_ptr_in = tag_wr_ptr_ff;
      tag_rd_ptr_in = tag_rd_ptr_ff;
      tag_fill_in   = tag_fill_ff;
      chunk_pos_in  = chunk_pos_ff;
      run_tag_ok_in = run_tag_ok_ff;
      run_pop_in    = run_pop_ff;
      run_buf_in    = run_buf_ff;
      run_level_in  = run_level_ff;
      frm_cnt_in    = frm_cnt_ff;

      if (do_write) begin
         wr_ptr_in = wr_ptr_next;
         if (fill_ff == FILL_W'(STORE_BYTES)) begin
            rd_ptr_in = rd_ptr_next;
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
         chunk_pos_in = (pos_inc >= eff_frame) ? '0 : pos_inc;
         if (req_data.chunk_end) begin
            chunk_pos_in = '0;
         end
         if (tag_push) begin
            tag_wr_ptr_in = tag_wr_next;
            if (tag_fill_ff == TFILL_W'(TAG_DEPTH)) begin
               tag_rd_ptr_in = tag_rd_next;
            end else begin
               tag_fill_in = tag_fill_ff + TFILL_W'(1);
            end
         end
      end

      if (do_read && (len_sat != '0)) begin
         frm_cnt_in = '0;
         if (silent) begin
            buffering_in  = buf0;
            run_tag_ok_in = 1'b0;
            run_pop_in    = 1'b0;
         end else if (full) begin
            buffering_in  = 1'b0;
            fill_in       = fill_ff - FILL_W'(len_sat);
            run_tag_ok_in = req_data.req_tagged && (tag_fill_ff != '0);
            run_pop_in    = req_data.req_tagged;
         end else begin
            // underrun: drain what is left, then buffer again
            buffering_in  = !fill_zero;
            fill_in       = '0;
            run_tag_ok_in = !fill_zero && req_data.req_tagged && (tag_fill_ff != '0);
            run_pop_in    = 1'b0;
            if (!fill_zero && req_data.req_tagged) begin
               tag_rd_ptr_in = tag_wr_ptr_ff;
               tag_fill_in   = '0;
            end
         end
         run_buf_in   = buffering_in;
         run_level_in = LEVEL_W'(fill_in);
      end

      if (do_clear) begin
         wr_ptr_in     = '0;
         rd_ptr_in     = '0;
         fill_in       = '0;
         tag_wr_ptr_in = '0;
         tag_rd_ptr_in = '0;
         tag_fill_in   = '0;
         chunk_pos_in  = '0;
      end

      if (byte_rd_en) begin
         rd_ptr_in = rd_ptr_next;
         if (run_pop_ff) begin
            // pop one tag per completed frame of the run
            if (frm_inc >= eff_frame) begin
               frm_cnt_in = '0;
               if (tag_fill_ff != '0) begin
                  tag_rd_ptr_in = tag_rd_next;
                  tag_fill_in   = tag_fill_ff - TFILL_W'(1);
               end
            end else begin
               frm_cnt_in = frm_inc;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      s1_data_in  = s1_data_ff;
      if (cmd.issue) begin
         s1_valid_in              = 1'b1;
         s1_data_in               = cmd.issue_data;
         s1_word_in.rd_byte       = '0;
         s1_word_in.is_silence    = !cmd.issue_data;
         s1_word_in.run_last      = cmd.issue_last;
         s1_word_in.tag_out       = run_tag_ok_ff ? tag_dout_ff : NO_TAG;
         s1_word_in.buffering_now = run_buf_ff;
         s1_word_in.level         = run_level_ff;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (s1_move) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in         = s1_word_ff;
         rsp_word_in.rd_byte = s1_data_ff ? byte_dout_ff : 8'd0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fill_ff       <= '0;
         buffering_ff  <= 1'b1;
         tag_wr_ptr_ff <= '0;
         tag_rd_ptr_ff <= '0;
         tag_fill_ff   <= '0;
         chunk_pos_ff  <= '0;
         run_tag_ok_ff <= 1'b0;
         run_pop_ff    <= 1'b0;
         run_buf_ff    <= 1'b1;
         frm_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fill_ff       <= fill_in;
         buffering_ff  <= buffering_in;
         tag_wr_ptr_ff <= tag_wr_ptr_in;
         tag_rd_ptr_ff <= tag_rd_ptr_in;
         tag_fill_ff   <= tag_fill_in;
         chunk_pos_ff  <= chunk_pos_in;
         run_tag_ok_ff <= run_tag_ok_in;
         run_pop_ff    <= run_pop_in;
         run_buf_ff    <= run_buf_in;
         frm_cnt_ff    <= frm_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_level_ff <= run_level_in;
      s1_word_ff   <= s1_word_in;
      s1_data_ff   <= s1_data_in;
      rsp_word_ff  <= rsp_word_in;
   end

   // byte ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         byte_mem[wr_ptr_ff] <= req_data.wr_byte;
      end
      if (byte_rd_en) begin
         byte_dout_ff <= byte_mem[rd_ptr_ff];
      end
   end

   // tag ring: head tag is fetched when a read is taken
   always_ff @(posedge clock) begin
      if (tag_push) begin
         tag_mem[tag_wr_ptr_ff] <= req_data.tag_in;
      end
      if (do_read) begin
         tag_dout_ff <= tag_mem[tag_rd_ptr_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

`default_nettype wire

>>> src/adaptive_playout_buffer.sv
// Adaptive playout buffer: byte ring with frame tags, silence fill and rebuffering.
// Top level; depends on aplb_pkg, aplb_csr, aplb_ctrl, aplb_dp and the defines header.
//
// Usage:
//   req_* carries one word per item: a write byte, a read request or a clear.
//   A word is taken when req_valid is high and req_stall is low.
//   Writes and clears give no result. A read of n bytes (n saturated to 64, zero
//   gives nothing) yields n result words on rsp_*, one per cycle while rsp_stall is
//   low. req_stall stays high while the read's n bytes are issued from the byte
//   ring's single read port, so a read occupies the input until its last byte is
//   issued. A two-entry result path (ring read stage plus output register) lets
//   the next word be taken while earlier results still wait. When the receiver
//   holds rsp_stall, the output word holds and issuing pauses. csr_* writes
//   start_level (0x0) and frame_bytes (0x4); the user must do so only while the
//   block is idle, which the block itself does not enforce. Reset empties both
//   rings, enters buffering mode and loads the default registers; ring memories
//   are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_playout_buffer_defines.svh"

module adaptive_playout_buffer
   import aplb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input word channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  req_word_type     req_data,
   // result word channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_word_type     rsp_data,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // register file
   aplb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: takes words, steps each read run one byte per cycle while the read stage has room
   aplb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // rings, read plan and result stages
   aplb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   // never issue into a read stage that is still occupied
   `APLB_ASSERT_SAME(a_issue_slot, cmd.issue, status.issue_ok, "issue into busy read stage")
   // a read that starts a run holds off the next word
   `APLB_ASSERT_NEXT(a_run_holds, cmd.accept && status.run_go, req_stall, "input open during run")
   // silence always carries a zero byte
   `APLB_ASSERT_SAME(a_silence_zero, rsp_valid && rsp_data.is_silence, rsp_data.rd_byte == 8'd0,
      "nonzero silence byte")

endmodule

`default_nettype wire
